>>> hdl/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg
// Shared constants and types for the Bresenham line stepper.
// ----------------------------------------------------------------------------
package bls_pkg;

   localparam int COORD_BITS_DEFAULT  = 10;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // command codes on req_cmd
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   // classification of one queued item
   typedef struct packed {
      logic start;
      logic y_down;
   } bls_ctl_type;

   localparam int CTL_BITS = $bits(bls_ctl_type);

endpackage

>>> hdl/bls_queue.sv
// ----------------------------------------------------------------------------
// bls_queue
// Small register queue between the front and the back of the line stepper.
// ----------------------------------------------------------------------------
module bls_queue #(
   parameter int DATA_BITS = 42,
   parameter int DEPTH     = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 push_full,
   output logic                 pop_valid,
   output logic [DATA_BITS-1:0] pop_data,
   input  logic                 pop_take
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [DATA_BITS-1:0] entry_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 push_fire;
   logic                 pop_fire;

   assign push_full = (count_ff == CNT_BITS'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign push_fire = push_valid && !push_full;
   assign pop_fire  = pop_take && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push_fire, pop_fire})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/bls_front.sv
// ----------------------------------------------------------------------------
// bls_front
// Accepts request items, orders start endpoints so x rises and forms deltas.
// ----------------------------------------------------------------------------
module bls_front #(
   parameter int COORD_BITS = bls_pkg::COORD_BITS_DEFAULT
) (
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_cmd,
   input  logic [COORD_BITS-1:0]   req_first_x,
   input  logic [COORD_BITS-1:0]   req_first_y,
   input  logic [COORD_BITS-1:0]   req_second_x,
   input  logic [COORD_BITS-1:0]   req_second_y,
   output logic                    push_valid,
   input  logic                    push_full,
   output bls_pkg::bls_ctl_type    push_ctl,
   output logic [COORD_BITS-1:0]   push_x,
   output logic [COORD_BITS-1:0]   push_y,
   output logic [COORD_BITS-1:0]   push_dx,
   output logic [COORD_BITS-1:0]   push_dy
);

   logic                  swap;
   logic [COORD_BITS-1:0] lo_x, hi_x, lo_y, hi_y;
   logic                  y_down;

   assign push_valid = req_valid;
   assign req_stall  = push_full;

   always_comb begin
      swap   = (req_first_x > req_second_x);
      lo_x   = swap ? req_second_x : req_first_x;
      lo_y   = swap ? req_second_y : req_first_y;
      hi_x   = swap ? req_first_x  : req_second_x;
      hi_y   = swap ? req_first_y  : req_second_y;
      y_down = (hi_y < lo_y);

      push_ctl.start  = (req_cmd == bls_pkg::CMD_START);
      push_ctl.y_down = y_down;
      push_x          = lo_x;
      push_y          = lo_y;
      push_dx         = hi_x - lo_x;
      push_dy         = y_down ? (lo_y - hi_y) : (hi_y - lo_y);
   end

endmodule

>>> hdl/bls_back.sv
// ----------------------------------------------------------------------------
// bls_back
// Holds the line state, runs the decision-term step and registers each pixel.
// ----------------------------------------------------------------------------
module bls_back #(
   parameter int COORD_BITS = bls_pkg::COORD_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   output logic                    pop_take,
   input  bls_pkg::bls_ctl_type    pop_ctl,
   input  logic [COORD_BITS-1:0]   pop_x,
   input  logic [COORD_BITS-1:0]   pop_y,
   input  logic [COORD_BITS-1:0]   pop_dx,
   input  logic [COORD_BITS-1:0]   pop_dy,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [COORD_BITS-1:0]   rsp_pixel_x,
   output logic [COORD_BITS-1:0]   rsp_pixel_y,
   output logic                    rsp_last
);

   localparam int DEC_BITS = COORD_BITS + 3;

   logic [COORD_BITS-1:0] cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0] cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0] remaining_ff, remaining_in;
   logic [DEC_BITS-1:0]   decision_ff, decision_in;
   logic [DEC_BITS-1:0]   inc_pos_ff, inc_pos_in;
   logic [DEC_BITS-1:0]   inc_neg_ff, inc_neg_in;
   logic                  y_down_ff, y_down_in;
   logic                  steep_ff, steep_in;
   logic                  active_ff, active_in;
   logic                  out_valid_ff, out_valid_in;
   logic [COORD_BITS-1:0] out_x_ff, out_x_in;
   logic [COORD_BITS-1:0] out_y_ff, out_y_in;
   logic                  out_last_ff, out_last_in;

   logic                  start_steep;
   logic [COORD_BITS-1:0] major, minor;
   logic                  move_minor;
   logic [COORD_BITS-1:0] y_moved;
   logic [COORD_BITS-1:0] step_x, step_y;
   logic [COORD_BITS-1:0] step_rem;

   assign pop_take    = pop_valid && (!out_valid_ff || !rsp_stall);
   assign rsp_valid   = out_valid_ff;
   assign rsp_pixel_x = out_x_ff;
   assign rsp_pixel_y = out_y_ff;
   assign rsp_last    = out_last_ff;

   always_comb begin
      start_steep = (pop_dy > pop_dx);
      major       = start_steep ? pop_dy : pop_dx;
      minor       = start_steep ? pop_dx : pop_dy;

      // non-negative decision term moves along the minor axis too
      move_minor = !decision_ff[DEC_BITS-1];
      y_moved    = y_down_ff ? (cur_y_ff - 1'b1) : (cur_y_ff + 1'b1);
      if (steep_ff) begin
         step_y = y_moved;
         step_x = move_minor ? (cur_x_ff + 1'b1) : cur_x_ff;
      end else begin
         step_x = cur_x_ff + 1'b1;
         step_y = move_minor ? y_moved : cur_y_ff;
      end
      step_rem = remaining_ff - 1'b1;

      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      remaining_in = remaining_ff;
      decision_in  = decision_ff;
      inc_pos_in   = inc_pos_ff;
      inc_neg_in   = inc_neg_ff;
      y_down_in    = y_down_ff;
      steep_in     = steep_ff;
      active_in    = active_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && rsp_stall;

      if (pop_take) begin
         if (pop_ctl.start) begin
            cur_x_in     = pop_x;
            cur_y_in     = pop_y;
            remaining_in = major;
            decision_in  = (DEC_BITS'(minor) << 1) - DEC_BITS'(major);
            inc_pos_in   = (DEC_BITS'(minor) - DEC_BITS'(major)) << 1;
            inc_neg_in   = DEC_BITS'(minor) << 1;
            y_down_in    = pop_ctl.y_down;
            steep_in     = start_steep;
            active_in    = (major != '0);
            out_valid_in = 1'b1;
            out_x_in     = pop_x;
            out_y_in     = pop_y;
            out_last_in  = (major == '0);
         end else if (active_ff) begin
            cur_x_in     = step_x;
            cur_y_in     = step_y;
            remaining_in = step_rem;
            decision_in  = decision_ff + (move_minor ? inc_pos_ff : inc_neg_ff);
            active_in    = (step_rem != '0);
            out_valid_in = 1'b1;
            out_x_in     = step_x;
            out_y_in     = step_y;
            out_last_in  = (step_rem == '0);
         end
         // drop a step that arrives while idle
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         remaining_ff <= '0;
         decision_ff  <= '0;
         inc_pos_ff   <= '0;
         inc_neg_ff   <= '0;
         y_down_ff    <= 1'b0;
         steep_ff     <= 1'b0;
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
         out_x_ff     <= '0;
         out_y_ff     <= '0;
         out_last_ff  <= 1'b0;
      end else begin
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         remaining_ff <= remaining_in;
         decision_ff  <= decision_in;
         inc_pos_ff   <= inc_pos_in;
         inc_neg_ff   <= inc_neg_in;
         y_down_ff    <= y_down_in;
         steep_ff     <= steep_in;
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
         out_x_ff     <= out_x_in;
         out_y_ff     <= out_y_in;
         out_last_ff  <= out_last_in;
      end
   end

endmodule

>>> hdl/bresenham_line_stepper_unit.sv
// ----------------------------------------------------------------------------
// bresenham_line_stepper_unit
// Bresenham line rasterizer for all octants, at most one pixel per item.
// ----------------------------------------------------------------------------
// A start item (cmd 0) carries two endpoints and yields the first pixel; each
// step item (cmd 1) yields the next pixel, and the pixel on the far endpoint
// has last set. Steps given while no line is in progress yield nothing, and a
// start drops any line in progress. The block takes one item per clock and
// gives one pixel per clock while rsp_stall is low: the stepper updates the
// decision term with a single add per pixel. A result appears on rsp the
// cycle after the item leaves the input queue; req_stall rises only when
// the QUEUE_DEPTH-entry input queue is full.
// COORD_BITS may range from 4 to 16, QUEUE_DEPTH from 2 upward.
module bresenham_line_stepper_unit #(
   parameter int COORD_BITS  = bls_pkg::COORD_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = bls_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd,
   input  logic [COORD_BITS-1:0] req_first_x,
   input  logic [COORD_BITS-1:0] req_first_y,
   input  logic [COORD_BITS-1:0] req_second_x,
   input  logic [COORD_BITS-1:0] req_second_y,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COORD_BITS-1:0] rsp_pixel_x,
   output logic [COORD_BITS-1:0] rsp_pixel_y,
   output logic                  rsp_last
);

   localparam int DATA_BITS = bls_pkg::CTL_BITS + 4 * COORD_BITS;

   logic                  q_push_valid;
   logic                  q_push_full;
   bls_pkg::bls_ctl_type  f_ctl;
   logic [COORD_BITS-1:0] f_x, f_y, f_dx, f_dy;
   logic [DATA_BITS-1:0]  q_push_data;
   logic                  q_pop_valid;
   logic                  q_pop_take;
   logic [DATA_BITS-1:0]  q_pop_data;
   bls_pkg::bls_ctl_type  b_ctl;
   logic [COORD_BITS-1:0] b_x, b_y, b_dx, b_dy;

   bls_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cmd      (req_cmd),
      .req_first_x  (req_first_x),
      .req_first_y  (req_first_y),
      .req_second_x (req_second_x),
      .req_second_y (req_second_y),
      .push_valid   (q_push_valid),
      .push_full    (q_push_full),
      .push_ctl     (f_ctl),
      .push_x       (f_x),
      .push_y       (f_y),
      .push_dx      (f_dx),
      .push_dy      (f_dy)
   );

   assign q_push_data = {f_ctl, f_x, f_y, f_dx, f_dy};

   bls_queue #(
      .DATA_BITS (DATA_BITS),
      .DEPTH     (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_data  (q_push_data),
      .push_full  (q_push_full),
      .pop_valid  (q_pop_valid),
      .pop_data   (q_pop_data),
      .pop_take   (q_pop_take)
   );

   assign {b_ctl, b_x, b_y, b_dx, b_dy} = q_pop_data;

   bls_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (q_pop_valid),
      .pop_take    (q_pop_take),
      .pop_ctl     (b_ctl),
      .pop_x       (b_x),
      .pop_y       (b_y),
      .pop_dx      (b_dx),
      .pop_dy      (b_dy),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_pixel_x (rsp_pixel_x),
      .rsp_pixel_y (rsp_pixel_y),
      .rsp_last    (rsp_last)
   );

   // an accepted item leaves the queue non-empty on the next cycle
   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> q_pop_valid)
      else $error("accepted item not visible in queue");

   // the front stalls only while the queue holds items
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> q_pop_valid)
      else $error("req_stall high with empty queue");

   // a new result always comes from an item taken off the queue
   a_rsp_from_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(q_pop_take))
      else $error("result appeared without a queue pop");

   // the back takes items only when the queue offers one
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop_take |-> q_pop_valid)
      else $error("pop from empty queue");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Bresenham line stepper unit.
// ----------------------------------------------------------------------------
// A table of directed items covers a single point, idle steps, restarts, the
// corner coordinates and each line shape. A random part follows with short
// lines at random places, some cut short or stepped past their end, and stray
// steps. A line tracer in the bench predicts each pixel, and every pixel on
// rsp is checked against the oldest one still due. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb;

   localparam int XY_BITS      = bls_pkg::COORD_BITS_DEFAULT;
   localparam int XY_MAX       = (1 << XY_BITS) - 1;
   localparam int RANDOM_ITEMS = 425;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SHOWN_FAULTS = 10;

   localparam logic [XY_BITS-1:0] TOP_XY    = XY_BITS'(XY_MAX);
   localparam logic [XY_BITS-1:0] TOP_XY_M1 = XY_BITS'(XY_MAX - 1);
   localparam logic [XY_BITS-1:0] TOP_XY_M3 = XY_BITS'(XY_MAX - 3);

   typedef struct packed {
      logic [XY_BITS-1:0] x;
      logic [XY_BITS-1:0] y;
      logic               last;
   } pixel_type;

   typedef struct {
      logic               cmd;
      logic [XY_BITS-1:0] fx;
      logic [XY_BITS-1:0] fy;
      logic [XY_BITS-1:0] sx;
      logic [XY_BITS-1:0] sy;
      bit                 typed;
      logic [XY_BITS-1:0] ex;
      logic [XY_BITS-1:0] ey;
      logic               el;
   } line_row_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_cmd;
   logic [XY_BITS-1:0] req_first_x;
   logic [XY_BITS-1:0] req_first_y;
   logic [XY_BITS-1:0] req_second_x;
   logic [XY_BITS-1:0] req_second_y;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [XY_BITS-1:0] rsp_pixel_x;
   logic [XY_BITS-1:0] rsp_pixel_y;
   logic               rsp_last;

   // pixel typed into the table, travels with the item it belongs to
   bit                 tag_typed;
   pixel_type          tag_pix;

   pixel_type          pixels_due[$];
   int                 faults = 0;
   int                 cycles = 0;
   bit                 calm = 1'b0;

   // line tracer state
   logic [XY_BITS-1:0] ln_x = '0;
   logic [XY_BITS-1:0] ln_y = '0;
   int                 ln_dx = 0;
   int                 ln_dy = 0;
   int                 ln_dec = 0;
   int                 ln_left = 0;
   bit                 ln_down = 1'b0;
   bit                 ln_steep = 1'b0;
   bit                 ln_busy = 1'b0;

   line_row_type       dir_rows [0:24];

   bresenham_line_stepper_unit #(.COORD_BITS(XY_BITS)) uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cmd      (req_cmd),
      .req_first_x  (req_first_x),
      .req_first_y  (req_first_y),
      .req_second_x (req_second_x),
      .req_second_y (req_second_y),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_pixel_x  (rsp_pixel_x),
      .rsp_pixel_y  (rsp_pixel_y),
      .rsp_last     (rsp_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Advance the line tracer by one item; returns 1 when a pixel comes out.
   function automatic bit trace_pixel(input logic cmd,
                                      input logic [XY_BITS-1:0] fx, fy, sx, sy,
                                      output pixel_type px);
      logic [XY_BITS-1:0] ax, ay, bx, by;
      int                 major, minor;
      bit                 bump;
      px = '0;
      if (cmd == bls_pkg::CMD_START) begin
         if (fx > sx) begin
            ax = sx; ay = sy; bx = fx; by = fy;
         end else begin
            ax = fx; ay = fy; bx = sx; by = sy;
         end
         ln_down  = by < ay;
         ln_dx    = int'(bx) - int'(ax);
         ln_dy    = ln_down ? int'(ay) - int'(by) : int'(by) - int'(ay);
         ln_steep = ln_dy > ln_dx;
         major    = ln_steep ? ln_dy : ln_dx;
         minor    = ln_steep ? ln_dx : ln_dy;
         ln_dec   = 2 * minor - major;
         ln_left  = major;
         ln_x     = ax;
         ln_y     = ay;
         ln_busy  = ln_left != 0;
      end else begin
         if (!ln_busy)
            return 1'b0;
         major  = ln_steep ? ln_dy : ln_dx;
         minor  = ln_steep ? ln_dx : ln_dy;
         bump   = ln_dec >= 0;
         ln_dec = ln_dec + (bump ? 2 * (minor - major) : 2 * minor);
         if (ln_steep) begin
            ln_y = ln_down ? ln_y - 1'b1 : ln_y + 1'b1;
            if (bump)
               ln_x = ln_x + 1'b1;
         end else begin
            ln_x = ln_x + 1'b1;
            if (bump)
               ln_y = ln_down ? ln_y - 1'b1 : ln_y + 1'b1;
         end
         ln_left = ln_left - 1;
         ln_busy = ln_left != 0;
      end
      px.x    = ln_x;
      px.y    = ln_y;
      px.last = ln_left == 0;
      return 1'b1;
   endfunction

   function automatic int idle_span();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         return $urandom_range(1, 3);
      else if (pick < 95)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic flag_fault(input string msg);
      faults++;
      if (faults <= SHOWN_FAULTS)
         $display("%s", msg);
   endtask

   // Present one item, hold it until taken, then maybe idle for a while.
   task automatic offer(input logic cmd,
                        input logic [XY_BITS-1:0] fx, fy, sx, sy,
                        input bit typed = 1'b0,
                        input logic [XY_BITS-1:0] ex = '0,
                        input logic [XY_BITS-1:0] ey = '0,
                        input logic el = 1'b0);
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_first_x  <= fx;
      req_first_y  <= fy;
      req_second_x <= sx;
      req_second_y <= sy;
      tag_typed    <= typed;
      tag_pix      <= '{ex, ey, el};
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat (idle_span()) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every pixel due has come back.
   task automatic await_pixels();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (pixels_due.size() != 0);
   endtask

   // rsp side: random stalls, mostly short, with calm stretches
   initial begin : rsp_pacing
      int hold_left;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            hold_left = idle_span() - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : watch_ports
      pixel_type px;
      pixel_type want;
      if (!reset && req_valid && !req_stall) begin
         if (trace_pixel(req_cmd, req_first_x, req_first_y, req_second_x,
                         req_second_y, px)) begin
            if (tag_typed)
               px = tag_pix;
            pixels_due.push_back(px);
         end
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixels_due.size() == 0) begin
            flag_fault($sformatf("unexpected pixel x=%0d y=%0d last=%0b",
                                 rsp_pixel_x, rsp_pixel_y, rsp_last));
         end else begin
            want = pixels_due.pop_front();
            if (rsp_pixel_x !== want.x || rsp_pixel_y !== want.y ||
                rsp_last !== want.last)
               flag_fault($sformatf(
                  "pixel mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                  want.x, want.y, want.last, rsp_pixel_x, rsp_pixel_y, rsp_last));
         end
      end
   end

   initial begin : stimulus
      int ax, ay, bx, by, ox, oy, reach, major, steps, extra, shape, lines, sent;
      lines = 0;
      sent  = 0;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_cmd      <= bls_pkg::CMD_START;
      req_first_x  <= '0;
      req_first_y  <= '0;
      req_second_x <= '0;
      req_second_y <= '0;
      tag_typed    <= 1'b0;
      tag_pix      <= '0;

      dir_rows = '{
         // an idle step after reset, a single point, then another idle step
         '{bls_pkg::CMD_STEP,  '0, '0, '0, '0, 1'b0, '0, '0, 1'b0},
         '{bls_pkg::CMD_START, 5, 7, 5, 7, 1'b1, 5, 7, 1'b1},
         '{bls_pkg::CMD_STEP,  TOP_XY, TOP_XY, TOP_XY, TOP_XY, 1'b0, '0, '0, 1'b0},
         // full falling diagonal, dropped after one step
         '{bls_pkg::CMD_START, TOP_XY, 0, 0, TOP_XY, 1'b1, 0, TOP_XY, 1'b0},
         '{bls_pkg::CMD_STEP,  '0, '0, '0, '0, 1'b0, '0, '0, 1'b0},
         // vertical at the far corner
         '{bls_pkg::CMD_START, TOP_XY, TOP_XY, TOP_XY, TOP_XY_M3, 1'b1, TOP_XY, TOP_XY, 1'b0},
         '{bls_pkg::CMD_STEP,  '0, '0, '0, '0, 1'b0, '0, '0, 1'b0},
         '{bls_pkg::CMD_STEP,  '0, '0, '0, '0, 1'b0, '0, '0, 1'b0},
         '{bls_pkg::CMD_STEP,  '0, '0, '0, '0, 1'b1, TOP_XY, TOP_XY_M3, 1'b1},
         // horizontal given right to left
         '{bls_pkg::CMD_START, 3, 0, 0, 0, 1'b1, 0, 0, 1'b0},
         '{bls_pkg::CMD_STEP,  '0, '0, '0, '0, 1'b0, '0, '0, 1'b0},
         '{bls_pkg::CMD_STEP,  '0, '0, '0, '0, 1'b0, '0, '0, 1'b0},
         '{bls_pkg::CMD_STEP,  '0, '0, '0, '0, 1'b1, 3, 0, 1'b1},
         // rising diagonal
         '{bls_pkg::CMD_START, 10, 20, 12, 22, 1'b1, 10, 20, 1'b0},
         '{bls_pkg::CMD_STEP,  '0, '0, '0, '0, 1'b0, '0, '0, 1'b0},
         '{bls_pkg::CMD_STEP,  '0, '0, '0, '0, 1'b1, 12, 22, 1'b1},
         // steep, y falling
         '{bls_pkg::CMD_START, TOP_XY_M1, 4, TOP_XY, 0, 1'b1, TOP_XY_M1, 4, 1'b0},
         '{bls_pkg::CMD_STEP,  '0, '0, '0, '0, 1'b0, '0, '0, 1'b0},
         '{bls_pkg::CMD_STEP,  '0, '0, '0, '0, 1'b0, '0, '0, 1'b0},
         '{bls_pkg::CMD_STEP,  '0, '0, '0, '0, 1'b0, '0, '0, 1'b0},
         '{bls_pkg::CMD_STEP,  '0, '0, '0, '0, 1'b1, TOP_XY, 0, 1'b1},
         // shallow, y rising
         '{bls_pkg::CMD_START, 0, 0, 3, 1, 1'b1, 0, 0, 1'b0},
         '{bls_pkg::CMD_STEP,  '0, '0, '0, '0, 1'b0, '0, '0, 1'b0},
         '{bls_pkg::CMD_STEP,  '0, '0, '0, '0, 1'b0, '0, '0, 1'b0},
         '{bls_pkg::CMD_STEP,  '0, '0, '0, '0, 1'b1, 3, 1, 1'b1}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         offer(dir_rows[i].cmd, dir_rows[i].fx, dir_rows[i].fy, dir_rows[i].sx,
               dir_rows[i].sy, dir_rows[i].typed, dir_rows[i].ex, dir_rows[i].ey,
               dir_rows[i].el);

      while (sent < RANDOM_ITEMS) begin
         calm = $urandom_range(0, 5) == 0;
         if ($urandom_range(0, 99) < 8) begin
            // stray step with junk endpoints
            offer(bls_pkg::CMD_STEP, XY_BITS'($urandom()), XY_BITS'($urandom()),
                  XY_BITS'($urandom()), XY_BITS'($urandom()));
            sent++;
         end else begin
            reach = ($urandom_range(0, 6) == 0) ? 40 : 12;
            ax = ($urandom_range(0, 9) == 0) ? XY_MAX * $urandom_range(0, 1)
                                             : $urandom_range(0, XY_MAX);
            ay = ($urandom_range(0, 9) == 0) ? XY_MAX * $urandom_range(0, 1)
                                             : $urandom_range(0, XY_MAX);
            ox = int'($urandom_range(0, 2 * reach)) - reach;
            oy = int'($urandom_range(0, 2 * reach)) - reach;
            shape = $urandom_range(0, 19);
            if (shape < 2)
               oy = 0;
            else if (shape < 4)
               ox = 0;
            else if (shape < 6)
               oy = ($urandom_range(0, 1) == 0) ? ox : -ox;
            else if (shape < 7) begin
               ox = 0;
               oy = 0;
            end
            bx = ax + ox;
            if (bx < 0 || bx > XY_MAX)
               bx = ax - ox;
            by = ay + oy;
            if (by < 0 || by > XY_MAX)
               by = ay - oy;
            ox = (ox < 0) ? -ox : ox;
            oy = (oy < 0) ? -oy : oy;
            major = (ox > oy) ? ox : oy;
            steps = major;
            extra = 0;
            // cut some lines short so the next start drops them
            if (major > 0 && $urandom_range(0, 6) == 0)
               steps = $urandom_range(0, major - 1);
            else if ($urandom_range(0, 4) == 0)
               extra = $urandom_range(1, 3);
            offer(bls_pkg::CMD_START, XY_BITS'(ax), XY_BITS'(ay), XY_BITS'(bx),
                  XY_BITS'(by));
            repeat (steps)
               offer(bls_pkg::CMD_STEP, XY_BITS'($urandom()), XY_BITS'($urandom()),
                     XY_BITS'($urandom()), XY_BITS'($urandom()));
            repeat (extra)
               offer(bls_pkg::CMD_STEP, XY_BITS'($urandom()), XY_BITS'($urandom()),
                     XY_BITS'($urandom()), XY_BITS'($urandom()));
            sent += 1 + steps + extra;
            // hold off the sender until every pixel is back
            if (lines == 5 || $urandom_range(0, 19) == 0)
               await_pixels();
            lines++;
         end
      end

      req_valid <= 1'b0;
      await_pixels();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (faults == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
